@@ hdl/nntm_pkg.sv @@
// Shared constants for the nearest-neighbour track mapper.
// Register indexes, request codes, result kinds and register reset values; no dependencies.
package nntm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_MINHIT = 2'd1;
  localparam logic [1:0] REG_FORGET = 2'd2;

  // Request codes
  localparam logic REQ_DETECT = 1'b0;
  localparam logic REQ_EOS    = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_CONE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Register reset values
  localparam logic [15:0] RADIUS_RST = 16'd200;
  localparam logic [15:0] MINHIT_RST = 16'd5;
  localparam logic [31:0] FORGET_RST = 32'd2000;

  localparam logic [15:0] HITS_MAX = 16'hFFFF;

endpackage

@@ hdl/nntm_if.sv @@
// Valid/ready channel interfaces for the track mapper: detection in, results out.
// Uses nothing from the package.
interface nntm_in_if #(parameter int CB = 18);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [CB-1:0] pos_x;
  logic signed [CB-1:0] pos_y;
  logic [31:0]          now_ms;
  modport source (output valid, req_type, pos_x, pos_y, now_ms, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, now_ms, output ready);
endinterface

interface nntm_out_if #(parameter int CB = 18);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [5:0]           slot;
  logic signed [CB-1:0] track_x_out;
  logic signed [CB-1:0] track_y_out;
  logic [15:0]          hit_count;
  logic [15:0]          cone_id;
  logic                 is_new;
  logic                 just_confirmed;
  logic                 dropped;
  logic                 last;
  modport source (output valid, kind, slot, track_x_out, track_y_out, hit_count, cone_id,
                  is_new, just_confirmed, dropped, last, input ready);
  modport sink   (input valid, kind, slot, track_x_out, track_y_out, hit_count, cone_id,
                  is_new, just_confirmed, dropped, last, output ready);
endinterface

@@ hdl/nntm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nntm_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/nntm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the running-mean update.
// Divisor up to 17 bits; no package dependency.
module nntm_div #(
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [16:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   q_r, q_nxt;
  logic [16:0]     rem_r, rem_nxt;
  logic [16:0]     dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r;
  logic [17:0]     trial;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem_r, q_r[DW-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = 17'(trial - {1'b0, dvs_r});
      q_nxt   = {q_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[16:0];
      q_nxt   = {q_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(DW);
        q_r   <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
      end else if (run_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ hdl/nearest_neighbor_track_mapper.sv @@
// Nearest-neighbour track mapper: usage notes below.
//
// Channels: in_ch takes items (detection or end of scan), out_ch gives result
// items, both valid/ready. cfg_we/cfg_idx/cfg_wdata write radius_mm, min_hits
// and forget_ms; write only while idle.
// A detection gives one result. It is matched against all stored tracks in a
// pipeline behind the track RAM, then the matched mean is updated by a
// bit-serial divider run twice, once per axis. An end of scan walks the table
// once, a RAM read then a compaction write per track, giving each confirmed
// track as it goes, the last one or an empty marker with last set.
// One item is in work at a time; a new item is accepted once the previous
// one has left its final result in the output register, even if that result
// still waits. A stalled receiver holds the block at its next result.
// Reset (rst_n low, synchronous) empties the table, zeroes the id counter and
// restores the register defaults; the track RAM needs no clearing pass.
// Depends on nntm_pkg, nntm_if, nntm_ram and nntm_div.
module nearest_neighbor_track_mapper
  import nntm_pkg::*;
#(
  parameter int TRACKS     = 64,
  parameter int COORD_BITS = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  nntm_in_if.sink      in_ch,
  nntm_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  localparam int CB = COORD_BITS;
  localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int CW = $clog2(TRACKS + 1);
  localparam int NW = CB + 17;
  localparam int DW = CB + 16;

  typedef struct packed {
    logic signed [CB-1:0] mx;
    logic signed [CB-1:0] my;
    logic [15:0]          hits;
    logic                 conf;
    logic [15:0]          id;
    logic [31:0]          seen;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SCAN  = 12'b000000000010,
    S_FETCH = 12'b000000000100,
    S_FWAIT = 12'b000000001000,
    S_MUL   = 12'b000000010000,
    S_DIVGO = 12'b000000100000,
    S_DIVW  = 12'b000001000000,
    S_UPD   = 12'b000010000000,
    S_NEW   = 12'b000100000000,
    S_PRD   = 12'b001000000000,
    S_PEVAL = 12'b010000000000,
    S_FLUSH = 12'b100000000000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [15:0] radius_r, minhit_r;
  logic [31:0] forget_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      minhit_r <= MINHIT_RST;
      forget_r <= FORGET_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIUS: radius_r <= cfg_wdata[15:0];
        REG_MINHIT: minhit_r <= cfg_wdata[15:0];
        REG_FORGET: forget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Track RAM
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic [EW-1:0] ram_rbits;

  nntm_ram #(.W(EW), .DEPTH(TRACKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = entry_t'(ram_rbits);

  // Item context
  logic [CW-1:0]        count_r;
  logic [15:0]          next_id_r;
  logic signed [CB-1:0] px_r, py_r;
  logic [31:0]          now_r;
  logic [31:0]          rad2_r;

  // Scan pipeline
  logic [CW-1:0] scan_i_r;
  logic          s1_v_r, a_v_r, b_v_r;
  logic [IW-1:0] s1_idx_r, a_idx_r, b_idx_r;
  logic [15:0]   ax_r, ay_r;
  logic          a_inr_r, b_inr_r;
  logic [31:0]   sqx_r, sqy_r;
  logic          found_r;
  logic [32:0]   best_d2_r;
  logic [IW-1:0] best_idx_r;
  logic          issue_en;
  logic [CB:0]   dx, dy, adx, ady;
  logic [32:0]   d2, d2_lim;

  assign issue_en = state_r == S_SCAN && scan_i_r < count_r;
  assign dx  = (CB + 1)'(ram_rdata.mx) - (CB + 1)'(px_r);
  assign dy  = (CB + 1)'(ram_rdata.my) - (CB + 1)'(py_r);
  assign adx = dx[CB] ? (CB + 1)'(-dx) : dx;
  assign ady = dy[CB] ? (CB + 1)'(-dy) : dy;
  assign d2  = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign d2_lim = found_r ? best_d2_r : {1'b0, rad2_r};

  // Mean update
  entry_t               ent_r;
  logic                 sel_r;
  logic signed [NW-1:0] prod_r, num;
  logic signed [CB-1:0] nx_r, p_sel;
  logic                 neg_r;
  logic [16:0]          dvs;
  logic [NW-1:0]        num_mag;
  logic [DW-1:0]        dividend, quot;
  logic                 div_start, div_done;
  logic signed [CB-1:0] q_signed;
  logic [15:0]          hits_new;
  logic                 conf_new;

  assign p_sel    = sel_r ? py_r : px_r;
  assign num      = prod_r + NW'(p_sel);
  assign num_mag  = num[NW-1] ? NW'(-num) : num;
  assign dvs      = {1'b0, ent_r.hits} + 17'd1;
  assign dividend = num_mag[DW-1:0] + DW'(dvs[16:1]);
  assign div_start = state_r == S_DIVGO;
  assign q_signed = neg_r ? CB'(-quot[CB-1:0]) : quot[CB-1:0];
  assign hits_new = (ent_r.hits == HITS_MAX) ? ent_r.hits : ent_r.hits + 16'd1;
  assign conf_new = !ent_r.conf && hits_new >= minhit_r;

  nntm_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot)
  );

  // Pruning walk
  logic [CW-1:0]        i_r, w_r;
  logic                 pend_v_r;
  logic [IW-1:0]        pend_slot_r;
  logic signed [CB-1:0] pend_x_r, pend_y_r;
  logic [15:0]          pend_hits_r, pend_id_r;
  logic                 keep, need_emit;
  logic [31:0]          age;

  assign age       = now_r - ram_rdata.seen;
  assign keep      = forget_r == 32'd0 || ram_rdata.conf || age <= forget_r;
  assign need_emit = keep && ram_rdata.conf && pend_v_r;

  // Output register
  logic                 out_free, emit;
  logic                 o_valid_r;
  logic [1:0]           o_kind_r, e_kind;
  logic [5:0]           o_slot_r, e_slot;
  logic signed [CB-1:0] o_x_r, o_y_r, e_x, e_y;
  logic [15:0]          o_hits_r, o_id_r, e_hits, e_id;
  logic                 o_new_r, o_jc_r, o_drop_r, o_last_r;
  logic                 e_new, e_jc, e_drop, e_last;

  assign out_free = !o_valid_r || out_ch.ready;

  // RAM access and result selection
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = scan_i_r[IW-1:0];
    ram_wdata = ent_r;
    emit      = 1'b0;
    e_kind    = KIND_ACK;
    e_slot    = '0;
    e_x       = '0;
    e_y       = '0;
    e_hits    = '0;
    e_id      = '0;
    e_new     = 1'b0;
    e_jc      = 1'b0;
    e_drop    = 1'b0;
    e_last    = 1'b0;
    case (state_r)
      S_SCAN: begin
        ram_re = issue_en;
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = best_idx_r;
      end
      S_PRD: begin
        ram_re    = 1'b1;
        ram_raddr = i_r[IW-1:0];
      end
      S_UPD: begin
        emit           = out_free;
        ram_we         = out_free;
        ram_waddr      = best_idx_r;
        ram_wdata.mx   = nx_r;
        ram_wdata.my   = q_signed;
        ram_wdata.hits = hits_new;
        ram_wdata.seen = now_r;
        if (conf_new) begin
          ram_wdata.conf = 1'b1;
          ram_wdata.id   = next_id_r;
        end
        e_slot = 6'(best_idx_r);
        e_x    = nx_r;
        e_y    = q_signed;
        e_hits = hits_new;
        e_id   = conf_new ? next_id_r : (ent_r.conf ? ent_r.id : 16'd0);
        e_jc   = conf_new;
        e_last = 1'b1;
      end
      S_NEW: begin
        emit   = out_free;
        e_last = 1'b1;
        if (count_r == CW'(TRACKS)) begin
          e_drop = 1'b1;
        end else begin
          ram_we         = out_free;
          ram_waddr      = count_r[IW-1:0];
          ram_wdata.mx   = px_r;
          ram_wdata.my   = py_r;
          ram_wdata.hits = 16'd1;
          ram_wdata.conf = 1'b0;
          ram_wdata.id   = 16'd0;
          ram_wdata.seen = now_r;
          e_slot = 6'(count_r[IW-1:0]);
          e_x    = px_r;
          e_y    = py_r;
          e_hits = 16'd1;
          e_new  = 1'b1;
        end
      end
      S_PEVAL: begin
        ram_we    = keep && (!need_emit || out_free);
        ram_waddr = w_r[IW-1:0];
        ram_wdata = ram_rdata;
        emit      = need_emit && out_free;
        e_kind    = KIND_CONE;
        e_slot    = 6'(pend_slot_r);
        e_x       = pend_x_r;
        e_y       = pend_y_r;
        e_hits    = pend_hits_r;
        e_id      = pend_id_r;
      end
      S_FLUSH: begin
        emit   = out_free;
        e_last = 1'b1;
        if (pend_v_r) begin
          e_kind = KIND_CONE;
          e_slot = 6'(pend_slot_r);
          e_x    = pend_x_r;
          e_y    = pend_y_r;
          e_hits = pend_hits_r;
          e_id   = pend_id_r;
        end else begin
          e_kind = KIND_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      next_id_r <= '0;
      s1_v_r    <= 1'b0;
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      found_r   <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      // scan pipeline stages run freely; only S_SCAN feeds them
      s1_v_r   <= issue_en;
      s1_idx_r <= scan_i_r[IW-1:0];
      a_v_r    <= s1_v_r;
      a_idx_r  <= s1_idx_r;
      ax_r     <= adx[15:0];
      ay_r     <= ady[15:0];
      a_inr_r  <= adx <= (CB + 1)'(radius_r) && ady <= (CB + 1)'(radius_r);
      b_v_r    <= a_v_r;
      b_idx_r  <= a_idx_r;
      b_inr_r  <= a_inr_r;
      sqx_r    <= ax_r * ax_r;
      sqy_r    <= ay_r * ay_r;
      if (b_v_r && b_inr_r && d2 <= d2_lim) begin
        found_r    <= 1'b1;
        best_d2_r  <= d2;
        best_idx_r <= b_idx_r;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            px_r     <= in_ch.pos_x;
            py_r     <= in_ch.pos_y;
            now_r    <= in_ch.now_ms;
            rad2_r   <= radius_r * radius_r;
            found_r  <= 1'b0;
            scan_i_r <= '0;
            i_r      <= '0;
            w_r      <= '0;
            pend_v_r <= 1'b0;
            if (in_ch.req_type == REQ_DETECT) begin
              state_r <= S_SCAN;
            end else if (count_r == '0) begin
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_PRD;
            end
          end
        end
        S_SCAN: begin
          if (issue_en) begin
            scan_i_r <= scan_i_r + 1'b1;
          end else if (!s1_v_r && !a_v_r && !b_v_r) begin
            state_r <= found_r ? S_FETCH : S_NEW;
          end
        end
        S_FETCH: state_r <= S_FWAIT;
        S_FWAIT: begin
          ent_r   <= ram_rdata;
          sel_r   <= 1'b0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= (sel_r ? ent_r.my : ent_r.mx) * $signed({1'b0, ent_r.hits});
          state_r <= S_DIVGO;
        end
        S_DIVGO: begin
          neg_r   <= num[NW-1];
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            if (!sel_r) begin
              nx_r    <= q_signed;
              sel_r   <= 1'b1;
              state_r <= S_MUL;
            end else begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (out_free) begin
            if (conf_new) begin
              next_id_r <= next_id_r + 16'd1;
            end
            state_r <= S_IDLE;
          end
        end
        S_NEW: begin
          if (out_free) begin
            if (count_r != CW'(TRACKS)) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_PRD: state_r <= S_PEVAL;
        S_PEVAL: begin
          if (!need_emit || out_free) begin
            if (keep) begin
              w_r <= w_r + 1'b1;
              if (ram_rdata.conf) begin
                pend_v_r    <= 1'b1;
                pend_slot_r <= w_r[IW-1:0];
                pend_x_r    <= ram_rdata.mx;
                pend_y_r    <= ram_rdata.my;
                pend_hits_r <= ram_rdata.hits;
                pend_id_r   <= ram_rdata.id;
              end
            end
            i_r     <= i_r + 1'b1;
            state_r <= (i_r + 1'b1 == count_r) ? S_FLUSH : S_PRD;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            count_r <= w_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (emit) begin
      o_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_kind_r <= e_kind;
      o_slot_r <= e_slot;
      o_x_r    <= e_x;
      o_y_r    <= e_y;
      o_hits_r <= e_hits;
      o_id_r   <= e_id;
      o_new_r  <= e_new;
      o_jc_r   <= e_jc;
      o_drop_r <= e_drop;
      o_last_r <= e_last;
    end
  end

  assign in_ch.ready           = state_r == S_IDLE;
  assign out_ch.valid          = o_valid_r;
  assign out_ch.kind           = o_kind_r;
  assign out_ch.slot           = o_slot_r;
  assign out_ch.track_x_out    = o_x_r;
  assign out_ch.track_y_out    = o_y_r;
  assign out_ch.hit_count      = o_hits_r;
  assign out_ch.cone_id        = o_id_r;
  assign out_ch.is_new         = o_new_r;
  assign out_ch.just_confirmed = o_jc_r;
  assign out_ch.dropped        = o_drop_r;
  assign out_ch.last           = o_last_r;

endmodule

@@ hdl/nntm_chk.sv @@
// Port-level checker for the track mapper, bound to the top level.
// Depends on nntm_pkg for the result kinds.
module nntm_chk
  import nntm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [5:0] out_slot,
  input logic       out_dropped,
  input logic       out_last
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot))
    else $error("stalled result changed");

  // One item in work at a time
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // A dropped detection is a lone acknowledge at slot zero
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_last && out_kind == KIND_ACK && out_slot == 6'd0)
    else $error("malformed drop result");

  // The empty marker closes its item
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EMPTY |-> out_last)
    else $error("empty marker without last");

  // Nothing comes out straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_neighbor_track_mapper nntm_chk u_nntm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_slot    (out_ch.slot),
  .out_dropped (out_ch.dropped),
  .out_last    (out_ch.last)
);
